// File: sv/pid_duty_controller_defines.svh
// assertion helpers shared by pdc_front and pdc_scale
`ifndef PID_DUTY_CONTROLLER_DEFINES_SVH
`define PID_DUTY_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define PDC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/pdc_pkg.sv
package pdc_pkg;

   localparam int IN_W      = 16;
   localparam int DUTY_W    = 7;
   localparam int GAIN_W    = 18;
   localparam int LIMIT_W   = 24;
   localparam int FRAC_W    = 16;
   localparam int PREV_W    = 28;
   localparam int SCALE     = 1000;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 3;

   localparam int REQ_W = 2 * IN_W;
   localparam int RSP_W = ((DUTY_W + 7) / 8) * 8;

   localparam int DIFF_W  = IN_W + 1;
   localparam int SCALE_W = $clog2(SCALE + 1);
   localparam int ERR_W   = DIFF_W + SCALE_W;
   localparam int DT_W    = ((PREV_W > ERR_W) ? PREV_W : ERR_W) + 1;
   localparam int ACC_W   = LIMIT_W + 2;

   localparam logic signed [SCALE_W:0] SCALE_S = (SCALE_W + 1)'(SCALE);

   // product and term widths
   localparam int P_PROD_W = GAIN_W + 1 + ERR_W;
   localparam int D_PROD_W = GAIN_W + 1 + DT_W;
   localparam int I_PROD_W = GAIN_W + LIMIT_W;
   localparam int P_MAG_W  = GAIN_W + ERR_W - 1 - FRAC_W;
   localparam int D_MAG_W  = GAIN_W + DT_W - 1 - FRAC_W;
   localparam int I_W      = GAIN_W + LIMIT_W - FRAC_W;
   localparam int P_T_W    = P_MAG_W + 1;
   localparam int D_T_W    = D_MAG_W + 1;
   localparam int PD_MAX   = (P_MAG_W > D_MAG_W) ? P_MAG_W : D_MAG_W;
   localparam int TERM_MAX = (PD_MAX > I_W) ? PD_MAX : I_W;
   localparam int MAG_W    = TERM_MAX + 2;
   localparam int SUM_W    = MAG_W + 1;

   localparam logic [FRAC_W-1:0] FRAC_MASK = '1;

   // divide by SCALE as multiply by a rounded-up reciprocal, exact below 2**MAG_W
   localparam int          DIV_SHIFT  = MAG_W + SCALE_W;
   localparam logic [63:0] DIV_MULT   = ((64'd1 << DIV_SHIFT) + 64'(SCALE) - 64'd1)
                                        / 64'(SCALE);
   localparam int          DIV_MULT_W = $clog2(DIV_MULT + 64'd1);
   localparam int          QPROD_W    = MAG_W + DIV_MULT_W;
   localparam int          QUO_W      = MAG_W - SCALE_W + 1;

   localparam logic [GAIN_W-1:0]  KP_RESET    = GAIN_W'(45875);
   localparam logic [GAIN_W-1:0]  KI_RESET    = GAIN_W'(655);
   localparam logic [GAIN_W-1:0]  KD_RESET    = GAIN_W'(6554);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10000000);
   localparam logic [DUTY_W-1:0]  DMIN_RESET  = DUTY_W'(5);
   localparam logic [DUTY_W-1:0]  DMAX_RESET  = DUTY_W'(95);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_GAIN        = 3'd0,
      CSR_KI_GAIN        = 3'd1,
      CSR_KD_GAIN        = 3'd2,
      CSR_INTEGRAL_LIMIT = 3'd3,
      CSR_DUTY_MIN       = 3'd4,
      CSR_DUTY_MAX       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  kp;
      logic [GAIN_W-1:0]  ki;
      logic [GAIN_W-1:0]  kd;
      logic [LIMIT_W-1:0] limit;
      logic [DUTY_W-1:0]  duty_min;
      logic [DUTY_W-1:0]  duty_max;
   } cfg_type;

   typedef struct packed {
      logic [IN_W-1:0] target;
      logic [IN_W-1:0] measured;
      logic            clear;
   } sample_type;

   typedef struct packed {
      logic [ERR_W-1:0]   err;
      logic [LIMIT_W-1:0] integ;
      logic [DT_W-1:0]    dt;
   } front_type;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } sum_type;

endpackage

// File: sv/pid_duty_controller.sv
// channel   | ports            | contents (lowest bits first)
// ----------+------------------+---------------------------------------------
// request   | req_t*           | tdata: target_value, measured_value
//           |                  | tuser: clear_integral
// response  | rsp_t*           | tdata: duty_percent, one zero pad bit
// csr       | csr_we/index/... | kp, ki, kd, integral_limit, duty_min, duty_max
//
// one request per cycle sustained while rsp_tready stays high; a request passes
// six registered stages: input register, error and integral, gain products, sum,
// reciprocal multiply for the divide by SCALE, clamp into the output register
// synchronous reset clears all stage valids, the integral and previous error,
// and loads the register defaults
// rsp_tready low holds the full stages; empty stages behind them keep filling,
// so req_tready drops only once all six stages hold a request
module pid_duty_controller (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pdc_pkg::REQ_W-1:0]      req_tdata,  // target_value, measured_value
   input  logic                           req_tuser,  // clear_integral

   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pdc_pkg::RSP_W-1:0]      rsp_tdata,  // duty_percent

   input  logic                           csr_we,
   input  logic [pdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pdc_pkg::CSR_W-1:0]      csr_wdata
);

   pdc_pkg::cfg_type    cfg_ff, cfg_in;
   pdc_pkg::sample_type smp;
   pdc_pkg::front_type  front_data;
   pdc_pkg::sum_type    sum_data;
   logic                front_valid, front_ready;
   logic                sum_valid, sum_ready;
   logic [pdc_pkg::DUTY_W-1:0] duty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pdc_pkg::CSR_KP_GAIN:        cfg_in.kp       = csr_wdata[pdc_pkg::GAIN_W-1:0];
            pdc_pkg::CSR_KI_GAIN:        cfg_in.ki       = csr_wdata[pdc_pkg::GAIN_W-1:0];
            pdc_pkg::CSR_KD_GAIN:        cfg_in.kd       = csr_wdata[pdc_pkg::GAIN_W-1:0];
            pdc_pkg::CSR_INTEGRAL_LIMIT: cfg_in.limit    = csr_wdata[pdc_pkg::LIMIT_W-1:0];
            pdc_pkg::CSR_DUTY_MIN:       cfg_in.duty_min = csr_wdata[pdc_pkg::DUTY_W-1:0];
            pdc_pkg::CSR_DUTY_MAX:       cfg_in.duty_max = csr_wdata[pdc_pkg::DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp       <= pdc_pkg::KP_RESET;
         cfg_ff.ki       <= pdc_pkg::KI_RESET;
         cfg_ff.kd       <= pdc_pkg::KD_RESET;
         cfg_ff.limit    <= pdc_pkg::LIMIT_RESET;
         cfg_ff.duty_min <= pdc_pkg::DMIN_RESET;
         cfg_ff.duty_max <= pdc_pkg::DMAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      smp.target   = req_tdata[pdc_pkg::IN_W-1:0];
      smp.measured = req_tdata[pdc_pkg::REQ_W-1:pdc_pkg::IN_W];
      smp.clear    = req_tuser;
   end

   pdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (smp),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   pdc_terms u_terms (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_data  (sum_data)
   );

   pdc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_data   (sum_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_duty  (duty)
   );

   assign rsp_tdata = {{(pdc_pkg::RSP_W - pdc_pkg::DUTY_W){1'b0}}, duty};

endmodule

// File: sv/pdc_front.sv
`include "pid_duty_controller_defines.svh"

module pdc_front (
   input  logic                clock,
   input  logic                reset,
   input  pdc_pkg::cfg_type    cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  pdc_pkg::sample_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output pdc_pkg::front_type  out_data
);

   pdc_pkg::sample_type smp_ff, smp_in;
   pdc_pkg::front_type  res_ff, res_in;
   logic                s0_valid_ff, s0_valid_in;
   logic                s1_valid_ff, s1_valid_in;
   logic [pdc_pkg::LIMIT_W-1:0]       integ_ff, integ_in;
   logic signed [pdc_pkg::PREV_W-1:0] prev_ff, prev_in;

   logic s0_rdy, s1_rdy, step;
   logic signed [pdc_pkg::DIFF_W-1:0]  diff;
   logic signed [pdc_pkg::ERR_W-1:0]   err;
   logic [pdc_pkg::LIMIT_W-1:0]        base;
   logic signed [pdc_pkg::ACC_W-1:0]   acc, limit_s;
   logic [pdc_pkg::LIMIT_W-1:0]        integ_new;
   logic signed [pdc_pkg::DT_W-1:0]    dt;

   always_comb begin
      s1_rdy = !s1_valid_ff || out_ready;
      s0_rdy = !s0_valid_ff || s1_rdy;
      step   = s0_valid_ff && s1_rdy;

      diff = pdc_pkg::DIFF_W'($signed(smp_ff.target))
           - pdc_pkg::DIFF_W'($signed(smp_ff.measured));
      err  = pdc_pkg::ERR_W'(diff) * pdc_pkg::ERR_W'(pdc_pkg::SCALE_S);

      // clear drops the old sum before this request is added
      base    = smp_ff.clear ? '0 : integ_ff;
      acc     = $signed({2'b00, base}) + pdc_pkg::ACC_W'(diff);
      limit_s = $signed({2'b00, cfg.limit});
      if (acc > limit_s) begin
         integ_new = cfg.limit;
      end else if (acc[pdc_pkg::ACC_W-1]) begin
         integ_new = '0;
      end else begin
         integ_new = acc[pdc_pkg::LIMIT_W-1:0];
      end

      // derivative term keeps the reversed sign
      dt = pdc_pkg::DT_W'(prev_ff) - pdc_pkg::DT_W'(err);

      smp_in      = s0_rdy ? in_data : smp_ff;
      s0_valid_in = s0_rdy ? in_valid : s0_valid_ff;
      s1_valid_in = s1_rdy ? s0_valid_ff : s1_valid_ff;

      res_in = res_ff;
      if (step) begin
         res_in.err   = err;
         res_in.integ = integ_new;
         res_in.dt    = dt;
      end

      integ_in = step ? integ_new : integ_ff;
      prev_in  = step ? pdc_pkg::PREV_W'(err) : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         integ_ff    <= '0;
         prev_ff     <= '0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         integ_ff    <= integ_in;
         prev_ff     <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in;
      res_ff <= res_in;
   end

   assign in_ready  = s0_rdy;
   assign out_valid = s1_valid_ff;
   assign out_data  = res_ff;

   `PDC_ASSERT_NEXT(a_clear_nonpositive_zeroes, step && smp_ff.clear && (diff[pdc_pkg::DIFF_W-1] || diff == '0), integ_ff == '0, "integral not zero after clear with non-positive error")
   `PDC_ASSERT_NEXT(a_state_holds_idle, !step, $stable(integ_ff) && $stable(prev_ff), "controller state changed without a request")

endmodule

// File: sv/pdc_terms.sv
module pdc_terms (
   input  logic               clock,
   input  logic               reset,
   input  pdc_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  pdc_pkg::front_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output pdc_pkg::sum_type   out_data
);

   logic signed [pdc_pkg::P_T_W-1:0] p_ff, p_in;
   logic signed [pdc_pkg::D_T_W-1:0] d_ff, d_in;
   logic [pdc_pkg::I_W-1:0]          i_ff, i_in;
   pdc_pkg::sum_type                 sum_ff, sum_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;

   logic s2_rdy, s3_rdy;
   logic signed [pdc_pkg::P_PROD_W-1:0] p_prod, p_bias;
   logic signed [pdc_pkg::D_PROD_W-1:0] d_prod, d_bias;
   logic [pdc_pkg::I_PROD_W-1:0]        i_prod;
   logic signed [pdc_pkg::SUM_W-1:0]    sum, sum_abs;

   always_comb begin
      s3_rdy = !s3_valid_ff || out_ready;
      s2_rdy = !s2_valid_ff || s3_rdy;

      p_prod = pdc_pkg::P_PROD_W'($signed({1'b0, cfg.kp}))
             * pdc_pkg::P_PROD_W'($signed(in_data.err));
      d_prod = pdc_pkg::D_PROD_W'($signed({1'b0, cfg.kd}))
             * pdc_pkg::D_PROD_W'($signed(in_data.dt));
      i_prod = pdc_pkg::I_PROD_W'(cfg.ki) * pdc_pkg::I_PROD_W'(in_data.integ);

      // bias negatives so the arithmetic shift truncates toward zero
      p_bias = p_prod + $signed({{(pdc_pkg::P_PROD_W - pdc_pkg::FRAC_W){1'b0}},
               pdc_pkg::FRAC_MASK & {pdc_pkg::FRAC_W{p_prod[pdc_pkg::P_PROD_W-1]}}});
      d_bias = d_prod + $signed({{(pdc_pkg::D_PROD_W - pdc_pkg::FRAC_W){1'b0}},
               pdc_pkg::FRAC_MASK & {pdc_pkg::FRAC_W{d_prod[pdc_pkg::D_PROD_W-1]}}});

      p_in = s2_rdy ? pdc_pkg::P_T_W'(p_bias >>> pdc_pkg::FRAC_W) : p_ff;
      d_in = s2_rdy ? pdc_pkg::D_T_W'(d_bias >>> pdc_pkg::FRAC_W) : d_ff;
      i_in = s2_rdy ? pdc_pkg::I_W'(i_prod >> pdc_pkg::FRAC_W) : i_ff;
      s2_valid_in = s2_rdy ? in_valid : s2_valid_ff;

      sum = pdc_pkg::SUM_W'(p_ff) + pdc_pkg::SUM_W'(d_ff)
          + $signed({{(pdc_pkg::SUM_W - pdc_pkg::I_W){1'b0}}, i_ff});
      sum_abs = sum[pdc_pkg::SUM_W-1] ? -sum : sum;

      sum_in = sum_ff;
      if (s3_rdy) begin
         sum_in.neg = sum[pdc_pkg::SUM_W-1];
         sum_in.mag = sum_abs[pdc_pkg::MAG_W-1:0];
      end
      s3_valid_in = s3_rdy ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      d_ff   <= d_in;
      i_ff   <= i_in;
      sum_ff <= sum_in;
   end

   assign in_ready  = s2_rdy;
   assign out_valid = s3_valid_ff;
   assign out_data  = sum_ff;

endmodule

// File: sv/pdc_scale.sv
`include "pid_duty_controller_defines.svh"

module pdc_scale (
   input  logic                        clock,
   input  logic                        reset,
   input  pdc_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  pdc_pkg::sum_type            in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [pdc_pkg::DUTY_W-1:0]  out_duty
);

   logic [pdc_pkg::QUO_W-1:0]  q_ff, q_in;
   logic                       neg_ff, neg_in;
   logic [pdc_pkg::MAG_W-1:0]  mag_ff, mag_in;
   logic [pdc_pkg::DUTY_W-1:0] duty_ff, duty_in;
   logic s4_valid_ff, s4_valid_in;
   logic s5_valid_ff, s5_valid_in;

   logic s4_rdy, s5_rdy;
   logic [pdc_pkg::QPROD_W-1:0] q_prod;
   logic [pdc_pkg::DUTY_W-1:0]  duty;
   logic [pdc_pkg::MAG_W-1:0]   q_back;

   always_comb begin
      s5_rdy = !s5_valid_ff || out_ready;
      s4_rdy = !s4_valid_ff || s5_rdy;

      // magnitude / SCALE, truncated
      q_prod = pdc_pkg::QPROD_W'(in_data.mag) * pdc_pkg::QPROD_W'(pdc_pkg::DIV_MULT);
      q_in   = s4_rdy ? pdc_pkg::QUO_W'(q_prod >> pdc_pkg::DIV_SHIFT) : q_ff;
      neg_in = s4_rdy ? in_data.neg : neg_ff;
      mag_in = s4_rdy ? in_data.mag : mag_ff;
      s4_valid_in = s4_rdy ? in_valid : s4_valid_ff;

      // when the limits cross, upper clamp wins only for a positive quotient above duty_max
      if (!neg_ff && q_ff > pdc_pkg::QUO_W'(cfg.duty_max)) begin
         duty = cfg.duty_max;
      end else if ((neg_ff && q_ff != '0) || q_ff < pdc_pkg::QUO_W'(cfg.duty_min)) begin
         duty = cfg.duty_min;
      end else begin
         duty = q_ff[pdc_pkg::DUTY_W-1:0];
      end

      duty_in     = s5_rdy ? duty : duty_ff;
      s5_valid_in = s5_rdy ? s4_valid_ff : s5_valid_ff;

      q_back = pdc_pkg::MAG_W'(q_ff) * pdc_pkg::MAG_W'(pdc_pkg::SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      duty_ff <= duty_in;
   end

   assign in_ready  = s4_rdy;
   assign out_valid = s5_valid_ff;
   assign out_duty  = duty_ff;

   `PDC_ASSERT_IMPL(a_quotient_exact, s4_valid_ff, q_back <= mag_ff && (mag_ff - q_back) < pdc_pkg::MAG_W'(pdc_pkg::SCALE), "reciprocal divide gave a wrong quotient")
   `PDC_ASSERT_IMPL(a_negative_nonzero, s4_valid_ff && neg_ff, mag_ff != '0, "negative sum with zero magnitude")

endmodule

// File: tb/sv/pid_duty_controller_tb.sv
`timescale 1ns / 1ps

module pid_duty_controller_tb;
   import pdc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam logic [GAIN_W-1:0]    GAIN_MAX    = '1;
   localparam logic [LIMIT_W-1:0]   LIMIT_MAX   = '1;
   localparam longint               GAIN_ONE    = 64'sd1 << FRAC_W;
   localparam int                   PHASES      = 9;
   localparam int                   PHASE_ITEMS = 70;
   localparam int                   LONG_HOLD   = 80;
   localparam int                   SETTLE      = 20;
   localparam int                   RUN_LIMIT   = 10_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;  // target_value, measured_value
   logic              req_tuser  = 1'b0;  // clear_integral

   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;  // duty_percent, pad bit

   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   pid_duty_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // controller copy: gains, limits and loop state
   logic [GAIN_W-1:0]  kp_gain_copy  = KP_RESET;
   logic [GAIN_W-1:0]  ki_gain_copy  = KI_RESET;
   logic [GAIN_W-1:0]  kd_gain_copy  = KD_RESET;
   logic [LIMIT_W-1:0] limit_copy    = LIMIT_RESET;
   logic [DUTY_W-1:0]  duty_min_copy = DMIN_RESET;
   logic [DUTY_W-1:0]  duty_max_copy = DMAX_RESET;
   longint             integral_acc  = 0;
   longint             last_error    = 0;

   sample_type        pending_requests[$];
   logic [DUTY_W-1:0] expected_duty[$];
   sample_type        offered;
   int                send_gap = 0, send_quiet = 0;
   int                recv_gap = 0, recv_quiet = 0;
   int                hold_left = 0, next_hold_at = 150;
   int                responses_seen = 0;
   int                mismatches = 0;

   function automatic logic [DUTY_W-1:0] compute_duty(sample_type s);
      longint diff, err, acc, p_term, i_term, d_term, duty;
      logic [PREV_W-1:0] err_low;
      diff = longint'($signed(s.target)) - longint'($signed(s.measured));
      err  = diff * SCALE;
      if (s.clear)
         integral_acc = 0;
      acc = integral_acc + diff;
      if (acc > longint'(limit_copy))
         acc = longint'(limit_copy);
      else if (acc < 0)
         acc = 0;
      integral_acc = acc;
      p_term = (longint'(kp_gain_copy) * err) / GAIN_ONE;
      i_term = (longint'(ki_gain_copy) * acc) / GAIN_ONE;
      d_term = (longint'(kd_gain_copy) * (last_error - err)) / GAIN_ONE;
      // only the low bits of the error survive into the next step
      err_low = err[PREV_W-1:0];
      last_error = longint'($signed(err_low));
      duty = (p_term + i_term + d_term) / SCALE;
      if (duty > longint'(duty_max_copy))
         duty = longint'(duty_max_copy);
      else if (duty < longint'(duty_min_copy))
         duty = longint'(duty_min_copy);
      return duty[DUTY_W-1:0];
   endfunction

   function automatic int pick_gap(ref int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         quiet = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   function automatic logic [IN_W-1:0] clip_input(longint v);
      if (v > 32767)
         v = 32767;
      else if (v < -32768)
         v = -32768;
      return v[IN_W-1:0];
   endfunction

   function automatic logic [IN_W-1:0] extreme_value();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h8001;
         2: return 16'hFFFF;
         3: return 16'h0000;
         4: return 16'h0001;
         default: return 16'h7FFF;
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain();
      if ($urandom_range(0, 1))
         return GAIN_W'($urandom_range(0, 262143));
      return GAIN_W'($urandom_range(0, 70000));
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_KP_GAIN:        kp_gain_copy  = value[GAIN_W-1:0];
         CSR_KI_GAIN:        ki_gain_copy  = value[GAIN_W-1:0];
         CSR_KD_GAIN:        kd_gain_copy  = value[GAIN_W-1:0];
         CSR_INTEGRAL_LIMIT: limit_copy    = value[LIMIT_W-1:0];
         CSR_DUTY_MIN:       duty_min_copy = value[DUTY_W-1:0];
         CSR_DUTY_MAX:       duty_max_copy = value[DUTY_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                                logic [GAIN_W-1:0] kd, logic [LIMIT_W-1:0] limit,
                                logic [DUTY_W-1:0] dmin, logic [DUTY_W-1:0] dmax);
      write_register(CSR_KP_GAIN, CSR_W'(kp));
      write_register(CSR_KI_GAIN, CSR_W'(ki));
      write_register(CSR_KD_GAIN, CSR_W'(kd));
      write_register(CSR_INTEGRAL_LIMIT, CSR_W'(limit));
      write_register(CSR_DUTY_MIN, CSR_W'(dmin));
      write_register(CSR_DUTY_MAX, CSR_W'(dmax));
   endtask

   task automatic queue_request(int target, int measured, bit clear);
      sample_type s;
      s.target   = clip_input(target);
      s.measured = clip_input(measured);
      s.clear    = clear;
      pending_requests.push_back(s);
   endtask

   task automatic queue_random_request();
      sample_type s;
      int r;
      r = $urandom_range(0, 99);
      s.measured = IN_W'($urandom);
      s.target   = IN_W'($urandom);
      s.clear    = ($urandom_range(0, 99) < 8);
      if (r < 40) begin
         // small error of up to 300 around the measurement
         s.target = clip_input(longint'($signed(s.measured))
                               + longint'($urandom_range(0, 600)) - 300);
      end else if (r < 60) begin
         s.target = IN_W'($urandom);
      end else if (r < 80) begin
         s.target   = extreme_value();
         s.measured = extreme_value();
      end else begin
         s.target = clip_input(longint'($signed(s.measured))
                               + longint'($urandom_range(1, 3000)));
      end
      pending_requests.push_back(s);
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_tvalid || expected_duty.size() != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin : drive_requests
      logic next_valid;
      next_valid = req_tvalid;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_duty.push_back(compute_duty(offered));
            next_valid = 1'b0;
            send_gap = pick_gap(send_quiet);
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() != 0) begin
               offered = pending_requests.pop_front();
               req_tdata <= {offered.measured, offered.target};
               req_tuser <= offered.clear;
               next_valid = 1'b1;
            end
         end
      end
      req_tvalid <= next_valid;
   end

   always @(posedge clock) begin : collect_responses
      logic next_ready;
      logic [DUTY_W-1:0] want;
      next_ready = 1'b1;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            if (expected_duty.size() == 0) begin
               report_mismatch($sformatf("unexpected response duty=%0d",
                                         rsp_tdata[DUTY_W-1:0]));
            end else begin
               want = expected_duty.pop_front();
               if (rsp_tdata[DUTY_W-1:0] !== want)
                  report_mismatch($sformatf("response %0d: duty=%0d, predicted %0d",
                                            responses_seen, rsp_tdata[DUTY_W-1:0], want));
            end
            recv_gap = pick_gap(recv_quiet);
         end
         // long hold while requests keep coming so the pipeline backs up
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (responses_seen >= next_hold_at && req_tvalid) begin
            hold_left = LONG_HOLD;
            next_hold_at += 300;
            next_ready = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            next_ready = 1'b0;
         end
      end
      rsp_tready <= next_ready;
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin : run_test
      int phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // register defaults
      queue_request(0, 0, 1'b0);
      queue_request(32767, -32768, 1'b0);
      queue_request(-32768, 32767, 1'b0);
      queue_request(100, 50, 1'b0);
      queue_request(100, 50, 1'b1);
      queue_request(50, 100, 1'b0);
      queue_request(-1, -1, 1'b0);
      queue_request(0, -1, 1'b0);
      queue_request(-32768, -32768, 1'b1);
      queue_request(32767, 32767, 0);
      wait_idle();

      // unit P and I gains, zero D gain, small integral limit, duty_max above 100
      load_settings(GAIN_W'(GAIN_ONE), GAIN_W'(GAIN_ONE), 0, 100, 0, 127);
      queue_request(200, 0, 1'b0);
      queue_request(120, 0, 1'b0);
      queue_request(126, 0, 1'b0);
      queue_request(-50, 0, 1'b0);
      queue_request(-500, 0, 1'b0);
      queue_request(30, 0, 1'b1);
      wait_idle();

      // crossed bounds, plus writes to unused indexes
      write_register(CSR_SPARE_6, 24'hFFFFFF);
      load_settings(GAIN_W'(GAIN_ONE), 0, 0, 100, 90, 10);
      write_register(CSR_SPARE_7, 24'h00007F);
      queue_request(50, 0, 1'b0);
      queue_request(5, 0, 1'b0);
      queue_request(-3, 0, 1'b0);
      queue_request(10, 0, 1'b0);
      wait_idle();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: load_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_MAX, 0, 100);
            1: load_settings(0, 0, 0, 0, 127, 101);
            2: load_settings(KP_RESET, KI_RESET, KD_RESET, LIMIT_RESET, DMIN_RESET,
                             DMAX_RESET);
            default: load_settings(random_gain(), random_gain(), random_gain(),
                                   LIMIT_W'($urandom_range(0, 1)
                                            ? $urandom_range(0, 16777215)
                                            : $urandom_range(0, 5000)),
                                   DUTY_W'($urandom_range(0, 50)),
                                   DUTY_W'($urandom_range(40, 127)));
         endcase
         if (phase == 5)
            write_register(CSR_SPARE_7, CSR_W'($urandom));
         @(negedge clock);
         repeat (PHASE_ITEMS) queue_random_request();
         wait_idle();
      end

      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: pid_duty_controller.f
+incdir+sv
sv/pdc_pkg.sv
sv/pdc_front.sv
sv/pdc_terms.sv
sv/pdc_scale.sv
sv/pid_duty_controller.sv
tb/sv/pid_duty_controller_tb.sv
